// ----- rtl/nsm_pkg.sv -----
`timescale 1ns / 1ps

package nsm_pkg;

	// Action codes of an input item.
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

	// Normalised z of 1.0 in unsigned Q1.15.
	localparam logic [15:0] Z_ONE = 16'd32768;

	// Largest output code, standing for 1.0 in Q0.16.
	localparam logic [15:0] OUT_MAX = 16'hffff;

	// Half an LSB of a Q2.60 product cut to Q1.30, used for round half up.
	localparam logic [61:0] Q30_HALF = 62'd1 << 29;

	// One stream position passed from the front to the back.
	typedef struct packed {
		logic [15:0] z;
		logic        frame;
	} nsm_entry_t;

endpackage

// ----- rtl/normal_slope_mask_filter_core.sv -----
`timescale 1ns / 1ps

// Slope mask filter: 3x3 minimum of normalised z over a raster stream of
// packed 10:10:10:2 normals, raised to the tenth power and given as Q0.16.
// Input channel (in_valid/in_ready): action selects a pixel or a drain step.
// Output channel (out_valid/out_ready): one result per frame pixel, in raster
// order, with its column, row and a frame_last flag on the final pixel.
// Configuration (cfg_we/cfg_index/cfg_data) sets width and height, and a
// write to either size restarts the stream; write only while the block is idle.
// Front: a pixel with a positive z component holds the front until it is pushed,
// through the bit-serial divider (33 steps) and square root (17 steps) of the
// decoder; a pixel whose z component is not positive skips both. A drain step
// does not use the decoder. The back uses its line store port for every position
// and its shared multiplier for a position with a result. A pixel's result
// follows once width+1 further positions have entered, through the back.
// A four-entry queue parts the front from the back, and the output register
// lets the back finish one more result while the receiver stalls.
// Reset returns both sizes to 1024 and clears all positions; the line store
// keeps its contents, whose stale values are not used until written again.

module normal_slope_mask_filter_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [31:0] normal_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] clutter_value,
	output logic [9:0]  pixel_column,
	output logic [9:0]  pixel_row,
	output logic        frame_last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	localparam logic [10:0] SIZE_RESET = 11'd1024;

	logic [10:0]         image_width_q;
	logic [10:0]         image_height_q;
	logic [WW-1:0]       eff_w;
	logic [HW-1:0]       eff_h;
	logic                restart;
	logic                push_valid;
	nsm_pkg::nsm_entry_t push_entry;
	logic                q_full;
	logic                q_pop;
	logic                q_valid;
	nsm_pkg::nsm_entry_t q_entry;

	assign restart = cfg_we && (cfg_index == nsm_pkg::CFG_IMAGE_WIDTH ||
		cfg_index == nsm_pkg::CFG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= SIZE_RESET;
			image_height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				nsm_pkg::CFG_IMAGE_WIDTH:  image_width_q <= cfg_data;
				nsm_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A size of zero acts as one, and a size above the maximum as the maximum.
	always_comb begin
		if (image_width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(image_width_q);
		end
		if (image_height_q == '0) begin
			eff_h = HW'(1);
		end else if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(image_height_q);
		end
	end

	nsm_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (restart),
		.img_w       (eff_w),
		.img_h       (eff_h),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.normal_word (normal_word),
		.push_valid  (push_valid),
		.push_entry  (push_entry),
		.push_full   (q_full)
	);

	nsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.flush      (restart),
		.push       (push_valid),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_entry (q_entry)
	);

	nsm_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (restart),
		.img_w         (eff_w),
		.img_h         (eff_h),
		.q_valid       (q_valid),
		.q_entry       (q_entry),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.clutter_value (clutter_value),
		.pixel_column  (pixel_column),
		.pixel_row     (pixel_row),
		.frame_last    (frame_last)
	);

endmodule

// ----- rtl/nsm_ram.sv -----
`timescale 1ns / 1ps

module nsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/nsm_decode.sv -----
`timescale 1ns / 1ps

module nsm_decode (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [29:0] word,
	output logic        done,
	output logic [15:0] z
);

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_DIV  = 2'd1;
	localparam logic [1:0] D_SQRT = 2'd2;
	localparam logic [1:0] D_DONE = 2'd3;

	logic [1:0]         state_q;
	logic [5:0]         cnt_q;
	logic [21:0]        s_q;
	logic [21:0]        rem_q;
	logic [32:0]        dvd_q;
	logic [31:0]        q_q;
	logic [33:0]        x_q;
	logic [16:0]        root_q;
	logic [19:0]        srem_q;
	logic [15:0]        z_q;

	logic signed [11:0] ax, ay, az;
	logic [23:0]        ax2, ay2, az2;
	logic [21:0]        s_sum;
	logic [22:0]        div_try;
	logic               div_ge;
	logic [21:0]        sq_v;
	logic [21:0]        sq_trial;
	logic               sq_ge;
	logic [16:0]        root_fin;
	logic [17:0]        z_round;

	// Each component c stands for (2c - 1023) / 1023; the common scale cancels.
	assign ax = $signed({1'b0, word[9:0], 1'b0}) - 12'sd1023;
	assign ay = $signed({1'b0, word[19:10], 1'b0}) - 12'sd1023;
	assign az = $signed({1'b0, word[29:20], 1'b0}) - 12'sd1023;
	assign ax2 = 24'(ax) * 24'(ax);
	assign ay2 = 24'(ay) * 24'(ay);
	assign az2 = 24'(az) * 24'(az);
	assign s_sum = 22'(ax2[19:0]) + 22'(ay2[19:0]) + 22'(az2[19:0]);

	// Restoring division of az^2 * 2^32 by s, one quotient bit per cycle.
	assign div_try = {rem_q, dvd_q[32]};
	assign div_ge  = div_try >= {1'b0, s_q};

	// Digit-by-digit square root, two radicand bits per cycle.
	assign sq_v     = {srem_q, x_q[33:32]};
	assign sq_trial = {3'b000, root_q, 2'b01};
	assign sq_ge    = sq_v >= sq_trial;
	assign root_fin = {root_q[15:0], sq_ge};
	assign z_round  = (18'(root_fin) + 18'd1) >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						if (az[11] || az == 12'sd0) begin
							state_q <= D_DONE;
						end else begin
							state_q <= D_DIV;
							cnt_q   <= 6'd32;
						end
					end
				end
				D_DIV: begin
					if (cnt_q == '0) begin
						state_q <= D_SQRT;
						cnt_q   <= 6'd16;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				D_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= D_DONE;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				D_DONE: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					z_q   <= '0;
					s_q   <= s_sum;
					rem_q <= 22'(az2[19:1]);
					dvd_q <= {az2[0], 32'd0};
					q_q   <= '0;
				end
			end
			D_DIV: begin
				rem_q <= div_ge ? 22'(div_try - {1'b0, s_q}) : div_try[21:0];
				q_q   <= {q_q[30:0], div_ge};
				dvd_q <= dvd_q << 1;
				if (cnt_q == '0) begin
					x_q    <= {1'b0, q_q, div_ge};
					root_q <= '0;
					srem_q <= '0;
				end
			end
			D_SQRT: begin
				srem_q <= sq_ge ? 20'(sq_v - sq_trial) : sq_v[19:0];
				root_q <= root_fin;
				x_q    <= x_q << 2;
				if (cnt_q == '0) begin
					z_q <= (z_round > 18'(nsm_pkg::Z_ONE)) ? nsm_pkg::Z_ONE : z_round[15:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign done = state_q == D_DONE;
	assign z    = z_q;

endmodule

// ----- rtl/nsm_front.sv -----
`timescale 1ns / 1ps

module nsm_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              restart,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]    img_w,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]   img_h,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic [31:0]                       normal_word,
	output logic                              push_valid,
	output nsm_pkg::nsm_entry_t               push_entry,
	input  logic                              push_full
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int CB = $clog2(MAX_WIDTH);
	localparam int RB = $clog2(MAX_HEIGHT);
	localparam int GW = $clog2(MAX_WIDTH + 2);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DEC  = 2'd1;
	localparam logic [1:0] F_PUT  = 2'd2;

	logic [1:0]    state_q;
	logic [CB-1:0] in_col_q;
	logic [RB-1:0] in_row_q;
	logic [GW-1:0] gap_q;
	logic          has_frame_q;
	logic [15:0]   z_hold_q;

	logic          accept;
	logic          is_pixel;
	logic          at_start;
	logic          pending;
	logic          frame_push;
	logic          any_push;
	logic          dec_done;
	logic [15:0]   dec_z;
	logic [WW-1:0] col_nx;
	logic [HW-1:0] row_nx;

	assign in_ready = state_q == F_IDLE && !push_full;
	assign accept   = in_valid && in_ready;
	assign is_pixel = action == nsm_pkg::ACT_PIXEL;
	assign at_start = in_col_q == '0 && in_row_q == '0;

	// A frame position stays pending until w+1 further positions have gone by,
	// so results are still owed exactly while the last frame position is that recent.
	assign pending    = has_frame_q && gap_q <= GW'(img_w);
	assign frame_push = is_pixel || !at_start;
	assign any_push   = frame_push || pending;

	assign col_nx = WW'(in_col_q) + 1'b1;
	assign row_nx = HW'(in_row_q) + 1'b1;

	nsm_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && is_pixel),
		.word   (normal_word[29:0]),
		.done   (dec_done),
		.z      (dec_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			in_col_q    <= '0;
			in_row_q    <= '0;
			gap_q       <= '0;
			has_frame_q <= 1'b0;
		end else if (restart) begin
			state_q     <= F_IDLE;
			in_col_q    <= '0;
			in_row_q    <= '0;
			gap_q       <= '0;
			has_frame_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept && is_pixel) begin
						state_q <= F_DEC;
					end
				end
				F_DEC: begin
					if (dec_done) begin
						state_q <= F_PUT;
					end
				end
				F_PUT: begin
					if (!push_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase

			if (accept && any_push) begin
				if (frame_push) begin
					gap_q       <= '0;
					has_frame_q <= 1'b1;
					if (col_nx >= img_w) begin
						in_col_q <= '0;
						in_row_q <= (row_nx >= img_h) ? '0 : RB'(row_nx);
					end else begin
						in_col_q <= CB'(col_nx);
					end
				end else if (gap_q <= GW'(img_w)) begin
					gap_q <= gap_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_DEC && dec_done) begin
			z_hold_q <= dec_z;
		end
	end

	always_comb begin
		if (state_q == F_PUT) begin
			push_valid       = !push_full;
			push_entry.z     = z_hold_q;
			push_entry.frame = 1'b1;
		end else begin
			push_valid       = accept && !is_pixel && any_push;
			push_entry.z     = '0;
			push_entry.frame = frame_push;
		end
	end

endmodule

// ----- rtl/nsm_queue.sv -----
`timescale 1ns / 1ps

module nsm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                flush,
	input  logic                push,
	input  nsm_pkg::nsm_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output nsm_pkg::nsm_entry_t head_entry
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	nsm_pkg::nsm_entry_t entry_q [DEPTH];
	logic [AW-1:0]       wr_ptr_q;
	logic [AW-1:0]       rd_ptr_q;
	logic [AW:0]         count_q;

	assign full       = count_q == (AW+1)'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_entry = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else if (flush) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ----- rtl/nsm_back.sv -----
`timescale 1ns / 1ps

module nsm_back #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            restart,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]  img_w,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0] img_h,
	input  logic                            q_valid,
	input  nsm_pkg::nsm_entry_t             q_entry,
	output logic                            q_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [15:0]                     clutter_value,
	output logic [9:0]                      pixel_column,
	output logic [9:0]                      pixel_row,
	output logic                            frame_last
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int CB = $clog2(MAX_WIDTH);
	localparam int RB = $clog2(MAX_HEIGHT);
	localparam int LW = 33;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_RD   = 3'd1;
	localparam logic [2:0] B_MIN  = 3'd2;
	localparam logic [2:0] B_POW  = 3'd3;
	localparam logic [2:0] B_OUT  = 3'd4;

	logic [2:0]          state_q;
	logic [2:0]          step_q;
	nsm_pkg::nsm_entry_t cur_q;
	logic [CB-1:0]       addr_q;
	logic [WW-1:0]       cnt_q;
	logic [CB-1:0]       out_col_q;
	logic [RB-1:0]       out_row_q;
	logic                mf0_q;
	logic [15:0]         b0_q, b1_q, b2_q;
	logic [15:0]         m0_q, m1_q, m2_q;
	logic [15:0]         t0_q, t1_q, t2_q;
	logic [15:0]         min_q;
	logic [30:0]         x2_q;
	logic [30:0]         acc_q;
	logic [15:0]         res_q;
	logic                out_valid_q;
	logic [15:0]         out_value_q;
	logic [CB-1:0]       out_col_s2;
	logic [RB-1:0]       out_row_s2;
	logic                out_last_q;

	logic [LW-1:0]       rd_data;
	logic [WW-1:0]       addr_nx;
	logic [WW-1:0]       col_nx;
	logic [HW-1:0]       row_nx;
	logic                up_ok, dn_ok, lf_ok, rt_ok;
	logic [15:0]         win_min;
	logic [30:0]         a_op, b_op;
	logic [61:0]         prod;
	logic [61:0]         prod_rnd;
	logic                load_out;

	assign q_pop    = state_q == B_IDLE && q_valid;
	assign addr_nx  = WW'(addr_q) + 1'b1;
	assign col_nx   = WW'(out_col_q) + 1'b1;
	assign row_nx   = HW'(out_row_q) + 1'b1;
	assign load_out = state_q == B_OUT && (!out_valid_q || out_ready);

	// Each line entry holds the newest value and the value one row older, so one
	// read gives both the middle and top rows of the window.
	nsm_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (state_q == B_RD),
		.waddr (addr_q),
		.wdata ({cur_q.z, cur_q.frame, rd_data[32:17]}),
		.re    (q_pop),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	// The centre tap is the position w+1 behind the newest one.
	assign up_ok = out_row_q != '0;
	assign dn_ok = row_nx < img_h;
	assign lf_ok = out_col_q != '0;
	assign rt_ok = col_nx < img_w;

	always_comb begin
		win_min = m1_q;
		if (up_ok && lf_ok && t2_q < win_min) win_min = t2_q;
		if (up_ok && t1_q < win_min) win_min = t1_q;
		if (up_ok && rt_ok && t0_q < win_min) win_min = t0_q;
		if (lf_ok && m2_q < win_min) win_min = m2_q;
		if (rt_ok && m0_q < win_min) win_min = m0_q;
		if (dn_ok && lf_ok && b2_q < win_min) win_min = b2_q;
		if (dn_ok && b1_q < win_min) win_min = b1_q;
		if (dn_ok && rt_ok && b0_q < win_min) win_min = b0_q;
	end

	// Shared multiplier: m^2, x2^2, x4^2, x8*x2, then the scale to Q0.16.
	always_comb begin
		case (step_q)
			3'd0: begin
				a_op = 31'(min_q);
				b_op = 31'(min_q);
			end
			3'd1: begin
				a_op = x2_q;
				b_op = x2_q;
			end
			3'd2: begin
				a_op = acc_q;
				b_op = acc_q;
			end
			3'd3: begin
				a_op = acc_q;
				b_op = x2_q;
			end
			default: begin
				a_op = acc_q;
				b_op = 31'(nsm_pkg::OUT_MAX);
			end
		endcase
	end

	assign prod     = 62'(a_op) * 62'(b_op);
	assign prod_rnd = prod + nsm_pkg::Q30_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= '0;
			addr_q      <= '0;
			cnt_q       <= '0;
			mf0_q       <= 1'b0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else if (restart) begin
			state_q   <= B_IDLE;
			step_q    <= '0;
			addr_q    <= '0;
			cnt_q     <= '0;
			mf0_q     <= 1'b0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						state_q <= B_RD;
					end
				end
				B_RD: begin
					addr_q <= (addr_nx >= img_w) ? '0 : CB'(addr_nx);
					if (cnt_q < img_w) begin
						cnt_q <= cnt_q + 1'b1;
					end
					// The line data means nothing until one full row has gone in.
					mf0_q   <= (cnt_q >= img_w) ? rd_data[16] : 1'b0;
					state_q <= mf0_q ? B_MIN : B_IDLE;
				end
				B_MIN: begin
					step_q  <= '0;
					state_q <= B_POW;
				end
				B_POW: begin
					if (step_q == 3'd4) begin
						state_q <= B_OUT;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				B_OUT: begin
					if (load_out) begin
						state_q <= B_IDLE;
						if (col_nx >= img_w) begin
							out_col_q <= '0;
							out_row_q <= (row_nx >= img_h) ? '0 : RB'(row_nx);
						end else begin
							out_col_q <= CB'(col_nx);
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_entry;
		end
		if (state_q == B_RD) begin
			b0_q <= cur_q.z;
			b1_q <= b0_q;
			b2_q <= b1_q;
			m0_q <= rd_data[32:17];
			m1_q <= m0_q;
			m2_q <= m1_q;
			t0_q <= rd_data[15:0];
			t1_q <= t0_q;
			t2_q <= t1_q;
		end
		if (state_q == B_MIN) begin
			min_q <= win_min;
		end
		if (state_q == B_POW) begin
			case (step_q)
				3'd0: x2_q <= prod[30:0];
				3'd1, 3'd2, 3'd3: acc_q <= prod_rnd[60:30];
				default: begin
					res_q <= (|prod_rnd[61:46]) ? nsm_pkg::OUT_MAX : prod_rnd[45:30];
				end
			endcase
		end
		if (load_out) begin
			out_value_q <= res_q;
			out_col_s2  <= out_col_q;
			out_row_s2  <= out_row_q;
			out_last_q  <= col_nx == img_w && row_nx == img_h;
		end
	end

	assign out_valid     = out_valid_q;
	assign clutter_value = out_value_q;
	assign pixel_column  = 10'(out_col_s2);
	assign pixel_row     = 10'(out_row_s2);
	assign frame_last    = out_last_q;

endmodule

// ----- rtl/nsm_checker.sv -----
`timescale 1ns / 1ps

module nsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        action,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] clutter_value,
	input logic [9:0]  pixel_column,
	input logic [9:0]  pixel_row,
	input logic        frame_last
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(clutter_value) &&
			$stable(pixel_column) && $stable(pixel_row) && $stable(frame_last))
		else $error("output result changed while stalled");

	// The result after the last pixel of a frame belongs to the first pixel.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && frame_last |=>
			!out_valid || (pixel_column == 10'd0 && pixel_row == 10'd0))
		else $error("result after frame end is not at the first pixel");

	// A pixel keeps the decoder busy, so no transfer follows in the next cycle.
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == nsm_pkg::ACT_PIXEL |=> !in_ready)
		else $error("input ready straight after a pixel transfer");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind normal_slope_mask_filter_core nsm_checker u_nsm_checker (.*);
